/* hw/rtl/ahnv_pkg.sv */
// Shared types, constants and the sine table generator for the note voice.
package ahnv_pkg;

    // Field and register widths
    localparam int CMD_W      = 1;
    localparam int STEP_W     = 31;
    localparam int LEN_W      = 20;
    localparam int ENV_W      = 23;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 23;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths of the mixer and scaler
    localparam int MAG_W      = 15;
    localparam int MIX_W      = 19;
    localparam int MIX_MAG_W  = 18;
    localparam int ENV_FRAC   = 22;

    localparam logic [ENV_W-1:0]    ENV_ONE = 23'h400000;
    localparam logic [SAMPLE_W-1:0] DAC_MID = 16'h8000;

    // Division by 7 as multiply by ceil(2^21 / 7), exact for the scaled mix range
    localparam logic [ENV_W-1:0] RECIP7       = 23'd299594;
    localparam int               RECIP7_SHIFT = 21;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_ATTACK_SAMPLES  = 20'd960;
    localparam logic [LEN_W-1:0] RST_DECAY_SAMPLES   = 20'd2400;
    localparam logic [LEN_W-1:0] RST_RELEASE_SAMPLES = 20'd2400;
    localparam logic [ENV_W-1:0] RST_ATTACK_STEP     = 23'd4369;
    localparam logic [ENV_W-1:0] RST_DECAY_STEP      = 23'd349;
    localparam logic [ENV_W-1:0] RST_RELEASE_STEP    = 23'd1748;
    localparam logic [ENV_W-1:0] RST_SUSTAIN_LEVEL   = 23'd3355443;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_SAMPLES  = 3'd0,
        REG_DECAY_SAMPLES   = 3'd1,
        REG_RELEASE_SAMPLES = 3'd2,
        REG_ATTACK_STEP     = 3'd3,
        REG_DECAY_STEP      = 3'd4,
        REG_RELEASE_STEP    = 3'd5,
        REG_SUSTAIN_LEVEL   = 3'd6
    } ahnv_reg_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } ahnv_cmd_t;

    typedef struct packed {
        ahnv_cmd_t           kind;
        logic [STEP_W-1:0]   phase_step;
        logic [LEN_W-1:0]    note_samples;
    } ahnv_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] attack_samples;
        logic [LEN_W-1:0] decay_samples;
        logic [LEN_W-1:0] release_samples;
        logic [ENV_W-1:0] attack_step;
        logic [ENV_W-1:0] decay_step;
        logic [ENV_W-1:0] release_step;
        logic [ENV_W-1:0] sustain_level;
    } ahnv_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_HARM,
        ST_MIX,
        ST_SCALE,
        ST_DIV
    } ahnv_state_t;

    // Quarter-wave entry k of a 2^tb table, Q30 Taylor series to the 13th power.
    // Called with constants only, so it folds away at elaboration.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned tb);
        logic [63:0]        x;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 j;
        x    = (64'(k) << 30) >> tb;
        a    = (x * HALF_PI_Q30) >> 30;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        for (j = 1; j <= 6; j++)
        begin
            term = (term * a2) >> 30;
            case (j)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (j[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[MAG_W-1:0];
    endfunction

endpackage

/* hw/rtl/ahnv_if.sv */
// Valid/ready channel interfaces for note commands and output samples.
interface ahnv_in_if;
    import ahnv_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [STEP_W-1:0]    phase_step;
    logic [LEN_W-1:0]     note_samples;

    modport source (output valid, output cmd, output phase_step, output note_samples,
                    input ready);
    modport sink   (input valid, input cmd, input phase_step, input note_samples,
                    output ready);
endinterface

interface ahnv_out_if;
    import ahnv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0]        dac_code;
    logic                       last;
    logic                       active;

    modport source (output valid, output sample, output dac_code, output last,
                    output active, input ready);
    modport sink   (input valid, input sample, input dac_code, input last,
                    input active, output ready);
endinterface

/* hw/rtl/adsr_harmonic_note_voice.sv */
// Note voice top level: ADSR envelope over a three-harmonic sine oscillator.
// Note samples pass the sequencer states IDLE, ENV, HARM, MIX, SCALE and DIV in turn,
// one tick at a time, sharing one multiplier and one sine table read port; DIV waits
// while the output register is full. An idle sample is loaded into the output register
// straight from the queue, also only when it is free; a start gives no sample.
// Reset: asynchronous, active low; voice idle, queue empty, registers at defaults.
module adsr_harmonic_note_voice
#(
    parameter int COUNT_BITS      = 20,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    ahnv_in_if.sink                           cmd_chan,
    ahnv_out_if.source                        sample_chan,
    input  logic                              cfg_we,
    input  logic [ahnv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahnv_pkg::CFG_W-1:0]        cfg_data
);
    import ahnv_pkg::*;

    ahnv_cfg_t  cfg;
    ahnv_item_t item;
    logic       item_valid;
    logic       pop;

    ahnv_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ahnv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_chan   (cmd_chan),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    ahnv_back #(
        .COUNT_BITS      (COUNT_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item        (item),
        .pop         (pop),
        .sample_chan (sample_chan)
    );

endmodule

/* hw/rtl/ahnv_regs.sv */
// Envelope configuration register file with write port.
module ahnv_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ahnv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahnv_pkg::CFG_W-1:0]        cfg_data,
    output ahnv_pkg::ahnv_cfg_t               cfg
);
    import ahnv_pkg::*;

    ahnv_cfg_t cfg_reg;
    ahnv_cfg_t cfg_next;

    // Decode the write and mask the data to the register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATTACK_SAMPLES:  cfg_next.attack_samples  = cfg_data[LEN_W-1:0];
                REG_DECAY_SAMPLES:   cfg_next.decay_samples   = cfg_data[LEN_W-1:0];
                REG_RELEASE_SAMPLES: cfg_next.release_samples = cfg_data[LEN_W-1:0];
                REG_ATTACK_STEP:     cfg_next.attack_step     = cfg_data[ENV_W-1:0];
                REG_DECAY_STEP:      cfg_next.decay_step      = cfg_data[ENV_W-1:0];
                REG_RELEASE_STEP:    cfg_next.release_step    = cfg_data[ENV_W-1:0];
                REG_SUSTAIN_LEVEL:   cfg_next.sustain_level   = cfg_data[ENV_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_samples  <= RST_ATTACK_SAMPLES;
            cfg_reg.decay_samples   <= RST_DECAY_SAMPLES;
            cfg_reg.release_samples <= RST_RELEASE_SAMPLES;
            cfg_reg.attack_step     <= RST_ATTACK_STEP;
            cfg_reg.decay_step      <= RST_DECAY_STEP;
            cfg_reg.release_step    <= RST_RELEASE_STEP;
            cfg_reg.sustain_level   <= RST_SUSTAIN_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/ahnv_front.sv */
// Command front end: accepts transfers, classifies them and queues them.
module ahnv_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    ahnv_in_if.sink               cmd_chan,
    input  logic                  pop,
    output logic                  item_valid,
    output ahnv_pkg::ahnv_item_t  item
);
    import ahnv_pkg::*;

    localparam int         DEPTH  = 2;
    localparam logic [1:0] FULL   = 2'(DEPTH);

    ahnv_item_t slot_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    ahnv_item_t entry;

    assign cmd_chan.ready = (count_reg != FULL);
    assign push           = cmd_chan.valid && cmd_chan.ready;

    // Classify the command into a queue entry
    always_comb
    begin
        entry.kind         = cmd_chan.cmd[0] ? CMD_START : CMD_TICK;
        entry.phase_step   = cmd_chan.phase_step;
        entry.note_samples = cmd_chan.note_samples;
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry on each transfer
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= entry;
    end

    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

endmodule

/* hw/rtl/ahnv_sine_rom.sv */
// Quarter-wave sine table with quadrant folding and registered read.
module ahnv_sine_rom
#(
    parameter int TABLE_BITS = 10
)
(
    input  logic                                 clk,
    input  logic [TABLE_BITS+1:0]                idx,
    output logic signed [ahnv_pkg::SAMPLE_W-1:0] value
);
    import ahnv_pkg::*;

    localparam int QUARTER = 1 << TABLE_BITS;
    localparam int AW      = TABLE_BITS + 1;

    logic [MAG_W-1:0]      entry [QUARTER+1];
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] k;
    logic [AW-1:0]         addr;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;
    logic                  neg_reg;
    logic                  neg_next;

    // Table contents fold to constants
    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_entry
        assign entry[g] = sine_entry(g, TABLE_BITS);
    end

    // Mirror the index in odd quadrants, negate in the lower half
    assign quad     = idx[TABLE_BITS+1:TABLE_BITS];
    assign k        = idx[TABLE_BITS-1:0];
    assign addr     = quad[0] ? (AW'(QUARTER) - {1'b0, k}) : {1'b0, k};
    assign mag_next = entry[addr];
    assign neg_next = quad[1];

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

/* hw/rtl/ahnv_back.sv */
// Voice back end: envelope, three-harmonic oscillator, scaling and output register.
module ahnv_back
#(
    parameter int COUNT_BITS      = 20,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ahnv_pkg::ahnv_cfg_t   cfg,
    input  logic                  item_valid,
    input  ahnv_pkg::ahnv_item_t  item,
    output logic                  pop,
    ahnv_out_if.source            sample_chan
);
    import ahnv_pkg::*;

    localparam int CB     = COUNT_BITS;
    localparam int PB     = PHASE_BITS;
    localparam int TB     = SINE_TABLE_BITS;
    localparam int CW     = (CB > LEN_W ? CB : LEN_W) + 1;
    localparam int MA_W   = (CB > MIX_MAG_W ? CB : MIX_MAG_W);
    localparam int PROD_W = MA_W + ENV_W;

    typedef enum logic [1:0] {
        ENV_RELEASE,
        ENV_ATTACK,
        ENV_DECAY,
        ENV_SUSTAIN
    } env_mode_t;

    // Sequencer
    ahnv_state_t state_reg;
    ahnv_state_t state_next;

    // Voice state
    logic [PB-1:0]    phase_reg;
    logic [PB-1:0]    phase_next;
    logic [PB-1:0]    step_reg;
    logic [PB-1:0]    step_next;
    logic [CB-1:0]    index_reg;
    logic [CB-1:0]    index_next;
    logic [CB-1:0]    length_reg;
    logic [CB-1:0]    length_next;
    logic [ENV_W-1:0] env_reg;
    logic [ENV_W-1:0] env_next;
    logic             released_reg;
    logic             released_next;
    logic             playing_reg;
    logic             playing_next;

    // Per-sample working registers
    env_mode_t                  mode_reg;
    env_mode_t                  mode_next;
    logic [MA_W-1:0]            opa_reg;
    logic [MA_W-1:0]            opa_next;
    logic [CB-1:0]              n_reg;
    logic [CB-1:0]              n_next;
    logic                       last_reg;
    logic                       last_next;
    logic signed [SAMPLE_W-1:0] s1_reg;
    logic signed [SAMPLE_W-1:0] s1_next;
    logic signed [SAMPLE_W-1:0] s2_reg;
    logic signed [SAMPLE_W-1:0] s2_next;
    logic [MIX_MAG_W-1:0]       mix_mag_reg;
    logic [MIX_MAG_W-1:0]       mix_mag_next;
    logic                       mix_neg_reg;
    logic                       mix_neg_next;
    logic [MIX_MAG_W-1:0]       scaled_reg;
    logic [MIX_MAG_W-1:0]       scaled_next;

    // Output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic signed [SAMPLE_W-1:0] out_sample_next;
    logic [SAMPLE_W-1:0]        out_dac_reg;
    logic [SAMPLE_W-1:0]        out_dac_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic                       out_active_reg;
    logic                       out_active_next;

    // Controls
    logic out_free;
    logic do_start;
    logic do_setup;
    logic emit_idle;
    logic emit_note;

    // Datapath nets
    logic [CB-1:0]              n;
    logic                       rel_now;
    logic                       in_attack;
    logic                       in_decay;
    env_mode_t                  mode_sel;
    logic [ENV_W-1:0]           sustain_cap;
    logic [MA_W-1:0]            mul_a;
    logic [ENV_W-1:0]           mul_b;
    logic [PROD_W-1:0]          product;
    logic [ENV_W-1:0]           env_calc;
    logic [PB-1:0]              phase2;
    logic [PB-1:0]              phase3;
    logic [TB+1:0]              rom_idx;
    logic signed [SAMPLE_W-1:0] rom_value;
    logic signed [MIX_W-1:0]    mix_sum;
    logic signed [MIX_W-1:0]    mix_abs;
    logic [MAG_W-1:0]           mag;
    logic signed [SAMPLE_W-1:0] mag_ext;
    logic signed [SAMPLE_W-1:0] sample_val;

    assign out_free = !out_valid_reg || sample_chan.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && item.kind == CMD_TICK && playing_reg)
                    state_next = ST_ENV;
            end
            ST_ENV:   state_next = ST_HARM;
            ST_HARM:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop       = 1'b0;
        do_start  = 1'b0;
        do_setup  = 1'b0;
        emit_idle = 1'b0;
        emit_note = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.kind == CMD_START)
                    begin
                        pop      = 1'b1;
                        do_start = 1'b1;
                    end
                    else if (playing_reg)
                    begin
                        pop      = 1'b1;
                        do_setup = 1'b1;
                    end
                    else if (out_free)
                    begin
                        pop       = 1'b1;
                        emit_idle = 1'b1;
                    end
                end
            end
            ST_DIV:   emit_note = out_free;
            default:  pop = 1'b0;
        endcase
    end

    // Sample count, release test and envelope stage
    assign n           = CB'(index_reg + 1'b1);
    assign rel_now     = released_reg ||
                         ((CW'(n) + CW'(cfg.release_samples)) > CW'(length_reg));
    assign in_attack   = CW'(n) < CW'(cfg.attack_samples);
    assign in_decay    = CW'(n) < (CW'(cfg.attack_samples) + CW'(cfg.decay_samples));
    assign sustain_cap = (cfg.sustain_level > ENV_ONE) ? ENV_ONE : cfg.sustain_level;

    always_comb
    begin
        if (rel_now)
            mode_sel = ENV_RELEASE;
        else if (in_attack)
            mode_sel = ENV_ATTACK;
        else if (in_decay)
            mode_sel = ENV_DECAY;
        else
            mode_sel = ENV_SUSTAIN;
    end

    // Shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_ENV:
            begin
                mul_a = opa_reg;
                mul_b = (mode_reg == ENV_ATTACK) ? cfg.attack_step : cfg.decay_step;
            end
            ST_SCALE:
            begin
                mul_a = MA_W'(mix_mag_reg);
                mul_b = env_reg;
            end
            default:
            begin
                mul_a = MA_W'(scaled_reg);
                mul_b = RECIP7;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Clamp the envelope for the current stage
    always_comb
    begin
        unique case (mode_reg)
            ENV_RELEASE:
                env_calc = (env_reg > cfg.release_step) ? (env_reg - cfg.release_step) : '0;
            ENV_ATTACK:
                env_calc = (product > PROD_W'(ENV_ONE)) ? ENV_ONE : product[ENV_W-1:0];
            ENV_DECAY:
                env_calc = (product >= PROD_W'(ENV_ONE - sustain_cap)) ? sustain_cap
                                                                       : (ENV_ONE - product[ENV_W-1:0]);
            default:
                env_calc = sustain_cap;
        endcase
    end

    // Table lookups of p, 2p and 3p in successive cycles
    assign phase2 = {phase_reg[PB-2:0], 1'b0};
    assign phase3 = phase_reg + phase2;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: rom_idx = phase_reg[PB-1 -: TB+2];
            ST_ENV:  rom_idx = phase2[PB-1 -: TB+2];
            default: rom_idx = phase3[PB-1 -: TB+2];
        endcase
    end

    ahnv_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk   (clk),
        .idx   (rom_idx),
        .value (rom_value)
    );

    // Weighted harmonic mix 4*s1 + 2*s2 + s3
    assign mix_sum = (MIX_W'(s1_reg) <<< 2) + (MIX_W'(s2_reg) <<< 1) + MIX_W'(rom_value);
    assign mix_abs = mix_sum[MIX_W-1] ? -mix_sum : mix_sum;

    // Final divide by 7 and sign
    assign mag        = product[RECIP7_SHIFT +: MAG_W];
    assign mag_ext    = $signed({1'b0, mag});
    assign sample_val = mix_neg_reg ? -mag_ext : mag_ext;

    // Voice and working register updates
    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        env_next      = env_reg;
        released_next = released_reg;
        playing_next  = playing_reg;
        mode_next     = mode_reg;
        opa_next      = opa_reg;
        n_next        = n_reg;
        last_next     = last_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        mix_mag_next  = mix_mag_reg;
        mix_neg_next  = mix_neg_reg;
        scaled_next   = scaled_reg;

        if (do_start)
        begin
            step_next     = PB'(item.phase_step);
            length_next   = CB'(item.note_samples);
            phase_next    = '0;
            index_next    = '0;
            env_next      = '0;
            released_next = 1'b0;
            playing_next  = (CB'(item.note_samples) != '0);
        end

        if (do_setup)
        begin
            released_next = rel_now;
            mode_next     = mode_sel;
            opa_next      = in_attack ? MA_W'(n) : MA_W'(n - CB'(cfg.attack_samples));
            n_next        = n;
            last_next     = (n >= length_reg);
        end

        case (state_reg)
            ST_ENV:
            begin
                env_next = env_calc;
                s1_next  = rom_value;
            end
            ST_HARM:  s2_next = rom_value;
            ST_MIX:
            begin
                mix_mag_next = mix_abs[MIX_MAG_W-1:0];
                mix_neg_next = mix_sum[MIX_W-1];
            end
            ST_SCALE: scaled_next = product[ENV_FRAC +: MIX_MAG_W];
            default:  scaled_next = scaled_reg;
        endcase

        if (emit_note)
        begin
            phase_next   = phase_reg + step_reg;
            index_next   = n_reg;
            playing_next = !last_reg;
        end
    end

    // Output register: load on emit, drop after the transfer
    always_comb
    begin
        out_valid_next  = out_valid_reg && !sample_chan.ready;
        out_sample_next = out_sample_reg;
        out_dac_next    = out_dac_reg;
        out_last_next   = out_last_reg;
        out_active_next = out_active_reg;
        if (emit_idle)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = '0;
            out_dac_next    = DAC_MID;
            out_last_next   = 1'b0;
            out_active_next = 1'b0;
        end
        else if (emit_note)
        begin
            // Magnitude stays within 32767, so offsetting never clamps
            out_valid_next  = 1'b1;
            out_sample_next = sample_val;
            out_dac_next    = sample_val ^ DAC_MID;
            out_last_next   = last_reg;
            out_active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            step_reg      <= '0;
            index_reg     <= '0;
            length_reg    <= '0;
            env_reg       <= '0;
            released_reg  <= 1'b0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            index_reg     <= index_next;
            length_reg    <= length_next;
            env_reg       <= env_next;
            released_reg  <= released_next;
            playing_reg   <= playing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers, no reset
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        opa_reg        <= opa_next;
        n_reg          <= n_next;
        last_reg       <= last_next;
        s1_reg         <= s1_next;
        s2_reg         <= s2_next;
        mix_mag_reg    <= mix_mag_next;
        mix_neg_reg    <= mix_neg_next;
        scaled_reg     <= scaled_next;
        out_sample_reg <= out_sample_next;
        out_dac_reg    <= out_dac_next;
        out_last_reg   <= out_last_next;
        out_active_reg <= out_active_next;
    end

    assign sample_chan.valid    = out_valid_reg;
    assign sample_chan.sample   = out_sample_reg;
    assign sample_chan.dac_code = out_dac_reg;
    assign sample_chan.last     = out_last_reg;
    assign sample_chan.active   = out_active_reg;

endmodule

/* hw/rtl/ahnv_checker.sv */
// Port-level checks for the note voice and their bind to the top level.
module ahnv_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ahnv_pkg::SAMPLE_W-1:0] out_sample,
    input logic [ahnv_pkg::SAMPLE_W-1:0]     out_dac_code,
    input logic                              out_last,
    input logic                              out_active
);
    import ahnv_pkg::*;

    // Hold a stalled sample transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) &&
        $stable(out_dac_code) && $stable(out_last) && $stable(out_active))
        else $error("stalled sample changed");

    // Keep a stalled command offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("stalled command dropped");

    // DAC code tracks the sample with offset binary
    a_dac_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_dac_code == (out_sample ^ DAC_MID))
        else $error("dac code does not match sample");

    // Idle samples are silent and never end a note
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_active |-> out_sample == '0 && !out_last)
        else $error("idle sample not silent");

    // Only a note sample can end a note
    a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_active)
        else $error("last flag on idle sample");

endmodule

bind adsr_harmonic_note_voice ahnv_checker u_ahnv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cmd_chan.valid),
    .in_ready     (cmd_chan.ready),
    .out_valid    (sample_chan.valid),
    .out_ready    (sample_chan.ready),
    .out_sample   (sample_chan.sample),
    .out_dac_code (sample_chan.dac_code),
    .out_last     (sample_chan.last),
    .out_active   (sample_chan.active)
);

/* dv/tb_top.sv */
// Self-checking testbench for the ADSR harmonic note voice: directed table, then random notes.
module tb_top;
    import ahnv_pkg::*;

    localparam int TBL_BITS         = 10;
    localparam int PH_BITS          = 32;
    localparam int TBL_SIZE         = 1 << TBL_BITS;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int SETTLE_CYCLES    = 16;
    localparam int HOLD_CYCLES      = 400;
    // Longest quiet stretch of a correct run is the long receiver hold-off; allow ten times that
    localparam int WATCHDOG_LIMIT   = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [63:0]          ENV_UNIT = 64'd1 << ENV_FRAC;

    localparam int SEND_IDLE_PCT  [4] = '{0, 52, 0, 21};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 52, 21};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0]        dac_code;
        logic                       last;
        logic                       active;
    } voice_sample_t;

    typedef struct packed {
        ahnv_cmd_t         kind;
        logic [STEP_W-1:0] step;
        logic [LEN_W-1:0]  len;
        logic              typed;
        voice_sample_t     res;
    } stim_row_t;

    localparam voice_sample_t IDLE_SAMPLE  = '{16'sd0, DAC_MID, 1'b0, 1'b0};
    localparam voice_sample_t FIRST_SAMPLE = '{16'sd0, DAC_MID, 1'b0, 1'b1};
    localparam voice_sample_t SILENT_LAST  = '{16'sd0, DAC_MID, 1'b1, 1'b1};

    // Idle samples, first note samples at phase zero and zero-step notes are typed in
    localparam int DIR_ROWS = 23;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, IDLE_SAMPLE},
        '{CMD_START, 31'h00000000, 20'h00000, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, IDLE_SAMPLE},
        '{CMD_START, 31'h00000000, 20'h00001, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, SILENT_LAST},
        '{CMD_TICK,  31'h7FFFFFFF, 20'hFFFFF, 1'b1, IDLE_SAMPLE},
        '{CMD_START, 31'h7FFFFFFF, 20'h00003, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, FIRST_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, IDLE_SAMPLE},
        '{CMD_START, 31'h40000000, 20'h00005, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, FIRST_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b0, IDLE_SAMPLE},
        '{CMD_START, 31'h15555555, 20'hFFFFF, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, FIRST_SAMPLE},
        '{CMD_TICK,  31'h7FFFFFFF, 20'hFFFFF, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h2AAAAAAA, 20'hAAAAA, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h55555555, 20'h55555, 1'b0, IDLE_SAMPLE},
        '{CMD_START, 31'h00000000, 20'h00002, 1'b0, IDLE_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, FIRST_SAMPLE},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, SILENT_LAST},
        '{CMD_TICK,  31'h00000000, 20'h00000, 1'b1, IDLE_SAMPLE}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ahnv_in_if  cmd_if ();
    ahnv_out_if smp_if ();

    adsr_harmonic_note_voice #(
        .COUNT_BITS      (LEN_W),
        .SINE_TABLE_BITS (TBL_BITS),
        .PHASE_BITS      (PH_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_chan    (cmd_if),
        .sample_chan (smp_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Voice model: registers, note state and quarter-wave table
    logic [LEN_W-1:0]    c_attack_n, c_decay_n, c_release_n;
    logic [ENV_W-1:0]    c_attack_step, c_decay_step, c_release_step, c_sustain;
    logic [PH_BITS-1:0]  v_phase, v_step;
    logic [LEN_W-1:0]    v_index, v_length;
    logic [ENV_W-1:0]    v_env;
    bit                  v_released, v_playing;
    logic [MAG_W-1:0]    sine_q [0:TBL_SIZE];

    voice_sample_t pending_samples [$];
    int            fail_count;
    int            items_sent;
    int            send_idle_pct;
    int            stall_pct;
    bit            hold_req;

    // Quarter-wave entry from a Q30 Taylor series up to the 13th power
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] x, a, a2, term, v;
        longint      sum;
        int          j;
        x    = (64'(k) << 30) >> TBL_BITS;
        a    = (x * HALF_PI_Q30) >> 30;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (j = 1; j <= 6; j++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * j) * (2 * j + 1));
            if (j % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[MAG_W-1:0];
    endfunction

    function automatic int sine_at(input logic [PH_BITS-1:0] p);
        logic [PH_BITS-1:0]  sh;
        logic [1:0]          quad;
        logic [TBL_BITS-1:0] k;
        int                  mag;
        sh   = p >> (PH_BITS - TBL_BITS - 2);
        quad = sh[TBL_BITS+1:TBL_BITS];
        k    = sh[TBL_BITS-1:0];
        mag  = quad[0] ? int'(sine_q[TBL_SIZE - k]) : int'(sine_q[k]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic void voice_reset_model();
        c_attack_n     = RST_ATTACK_SAMPLES;
        c_decay_n      = RST_DECAY_SAMPLES;
        c_release_n    = RST_RELEASE_SAMPLES;
        c_attack_step  = RST_ATTACK_STEP;
        c_decay_step   = RST_DECAY_STEP;
        c_release_step = RST_RELEASE_STEP;
        c_sustain      = RST_SUSTAIN_LEVEL;
        v_phase        = '0;
        v_step         = '0;
        v_index        = '0;
        v_length       = '0;
        v_env          = '0;
        v_released     = 1'b0;
        v_playing      = 1'b0;
    endfunction

    function automatic void voice_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        case (idx)
            REG_ATTACK_SAMPLES:  c_attack_n     = data[LEN_W-1:0];
            REG_DECAY_SAMPLES:   c_decay_n      = data[LEN_W-1:0];
            REG_RELEASE_SAMPLES: c_release_n    = data[LEN_W-1:0];
            REG_ATTACK_STEP:     c_attack_step  = data[ENV_W-1:0];
            REG_DECAY_STEP:      c_decay_step   = data[ENV_W-1:0];
            REG_RELEASE_STEP:    c_release_step = data[ENV_W-1:0];
            REG_SUSTAIN_LEVEL:   c_sustain      = data[ENV_W-1:0];
            default:             ;
        endcase
    endfunction

    // Envelope for sample number n (one-based) of the note
    function automatic logic [ENV_W-1:0] envelope_next(input logic [63:0] n);
        logic [63:0] sus, att, dec, e, drop;
        sus = (c_sustain > ENV_ONE) ? ENV_UNIT : 64'(c_sustain);
        att = 64'(c_attack_n);
        dec = 64'(c_decay_n);
        if (v_released)
            return (v_env > c_release_step) ? v_env - c_release_step : '0;
        if (n < att)
        begin
            e = n * 64'(c_attack_step);
            return (e > ENV_UNIT) ? ENV_ONE : e[ENV_W-1:0];
        end
        if (n < att + dec)
        begin
            drop = (n - att) * 64'(c_decay_step);
            return (drop >= ENV_UNIT - sus) ? sus[ENV_W-1:0] : ENV_W'(ENV_UNIT - drop);
        end
        return sus[ENV_W-1:0];
    endfunction

    // Advance the voice by one command; returns 1 when a sample is produced
    function automatic bit voice_predict(input ahnv_item_t it, output voice_sample_t r);
        logic [63:0]        n, mag;
        logic [PH_BITS-1:0] p2, p3;
        int                 m, s, d;
        bit                 neg;
        r = IDLE_SAMPLE;
        if (it.kind == CMD_START)
        begin
            v_step     = PH_BITS'(it.phase_step);
            v_length   = it.note_samples;
            v_phase    = '0;
            v_index    = '0;
            v_env      = '0;
            v_released = 1'b0;
            v_playing  = (it.note_samples != '0);
            return 1'b0;
        end
        if (!v_playing)
            return 1'b1;
        n = 64'(v_index) + 64'd1;
        if (n + 64'(c_release_n) > 64'(v_length))
            v_released = 1'b1;
        v_env = envelope_next(n);
        p2    = v_phase << 1;
        p3    = v_phase + p2;
        m     = 4 * sine_at(v_phase) + 2 * sine_at(p2) + sine_at(p3);
        neg   = (m < 0);
        mag   = 64'(neg ? -m : m) * 64'(v_env) / (64'd7 * ENV_UNIT);
        s     = neg ? -int'(mag) : int'(mag);
        d     = s + 32768;
        if (d < 0)
            d = 0;
        if (d > 65535)
            d = 65535;
        v_phase  = v_phase + v_step;
        v_index  = n[LEN_W-1:0];
        r.sample   = SAMPLE_W'(s);
        r.dac_code = SAMPLE_W'(d);
        r.last     = (n >= 64'(v_length));
        r.active   = 1'b1;
        if (r.last)
            v_playing = 1'b0;
        return 1'b1;
    endfunction

    // Offer one command, hold it until the transfer, then predict its sample
    task automatic offer_item(input ahnv_item_t it, input bit typed, input voice_sample_t want);
        voice_sample_t r;
        bit            has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.cmd          <= it.kind;
        cmd_if.phase_step   <= it.phase_step;
        cmd_if.note_samples <= it.note_samples;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent++;
        has = voice_predict(it, r);
        if (has)
            pending_samples.push_back(typed ? want : r);
    endtask

    task automatic offer_start(input logic [STEP_W-1:0] step, input logic [LEN_W-1:0] len);
        ahnv_item_t it;
        it.kind         = CMD_START;
        it.phase_step   = step;
        it.note_samples = len;
        offer_item(it, 1'b0, IDLE_SAMPLE);
    endtask

    task automatic offer_tick();
        ahnv_item_t it;
        it.kind         = CMD_TICK;
        it.phase_step   = STEP_W'($urandom);
        it.note_samples = LEN_W'($urandom);
        offer_item(it, 1'b0, IDLE_SAMPLE);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        voice_write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Program one envelope setting per phase; upper data bits probe the 20-bit masks
    task automatic program_voice(input int ph);
        case (ph)
            0:
            begin
                write_reg(REG_ATTACK_SAMPLES,  23'd4);
                write_reg(REG_DECAY_SAMPLES,   23'd6);
                write_reg(REG_RELEASE_SAMPLES, 23'd5);
                write_reg(REG_ATTACK_STEP,     23'h100000);
                write_reg(REG_DECAY_STEP,      23'd300000);
                write_reg(REG_RELEASE_STEP,    23'd500000);
                write_reg(REG_SUSTAIN_LEVEL,   23'h200000);
            end
            1:
            begin
                write_reg(REG_ATTACK_SAMPLES,  23'h700000);
                write_reg(REG_DECAY_SAMPLES,   23'h700000);
                write_reg(REG_RELEASE_SAMPLES, 23'h700000);
                write_reg(REG_ATTACK_STEP,     23'h7FFFFF);
                write_reg(REG_DECAY_STEP,      23'h7FFFFF);
                write_reg(REG_RELEASE_STEP,    23'h7FFFFF);
                write_reg(REG_SUSTAIN_LEVEL,   23'h7FFFFF);
            end
            2:
            begin
                write_reg(REG_ATTACK_SAMPLES,  23'h0FFFFF);
                write_reg(REG_DECAY_SAMPLES,   23'h7FFFFF);
                write_reg(REG_RELEASE_SAMPLES, 23'd1);
                write_reg(REG_ATTACK_STEP,     23'h400000);
                write_reg(REG_DECAY_STEP,      23'd0);
                write_reg(REG_RELEASE_STEP,    23'd0);
                write_reg(REG_SUSTAIN_LEVEL,   23'd0);
            end
            default:
            begin
                write_reg(REG_ATTACK_SAMPLES,  {3'($urandom), 20'($urandom_range(12))});
                write_reg(REG_DECAY_SAMPLES,   {3'($urandom), 20'($urandom_range(12))});
                write_reg(REG_RELEASE_SAMPLES,
                          ($urandom_range(3) == 0) ? 23'hFFFFF : 23'($urandom_range(12)));
                write_reg(REG_ATTACK_STEP,     23'($urandom));
                write_reg(REG_DECAY_STEP,      23'($urandom));
                write_reg(REG_RELEASE_STEP,    23'($urandom));
                write_reg(REG_SUSTAIN_LEVEL,   23'($urandom));
            end
        endcase
        // Out-of-range index must leave every register alone
        write_reg(REG_NONE, 23'($urandom));
    endtask

    // Mostly whole notes with random content; the rest is restarts, long and empty notes and bare ticks
    task automatic run_notes(input int count);
        int target;
        int len;
        int ticks;
        int roll;
        target = items_sent + count;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 72)
            begin
                len   = ($urandom_range(7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
                ticks = ($urandom_range(9) == 0) ? $urandom_range(0, len)
                                                 : len + $urandom_range(0, 3);
                offer_start(STEP_W'($urandom), LEN_W'(len));
            end
            else if (roll < 84)
            begin
                ticks = $urandom_range(0, 8);
                offer_start(STEP_W'($urandom), LEN_W'($urandom));
            end
            else if (roll < 92)
            begin
                ticks = $urandom_range(1, 3);
                offer_start(STEP_W'($urandom), '0);
            end
            else
                ticks = $urandom_range(1, 5);
            repeat (ticks)
                offer_tick();
        end
    endtask

    // Drop valid, wait for every pending sample, then let the pipeline settle
    task automatic finish_phase();
        cmd_if.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Sample receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        smp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                smp_if.ready <= 1'b0;
            end
            else
                smp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each sample transfer with the oldest pending sample
    always @(posedge clk)
    begin
        voice_sample_t want;
        if (smp_if.valid && smp_if.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample transfer with nothing pending: sample %0d", smp_if.sample);
                fail_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (smp_if.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d",
                           $signed(want.sample), $signed(smp_if.sample));
                    fail_count++;
                end
                if (smp_if.dac_code !== want.dac_code)
                begin
                    $error("dac_code: expected %0d, got %0d", want.dac_code, smp_if.dac_code);
                    fail_count++;
                end
                if (smp_if.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, smp_if.last);
                    fail_count++;
                end
                if (smp_if.active !== want.active)
                begin
                    $error("active: expected %0b, got %0b", want.active, smp_if.active);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer or register write
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (smp_if.valid && smp_if.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** adsr_harmonic_note_voice: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed table, then four random phases
    initial
    begin
        int         ph;
        int         i;
        int         k;
        ahnv_item_t it;
        fail_count    = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        for (k = 0; k <= TBL_SIZE; k++)
            sine_q[k] = quarter_sine(k);
        voice_reset_model();

        rst_n               <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.cmd          <= CMD_TICK;
        cmd_if.phase_step   <= '0;
        cmd_if.note_samples <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at reset register values
        for (i = 0; i < DIR_ROWS; i++)
        begin
            it.kind         = DIRECTED[i].kind;
            it.phase_step   = DIRECTED[i].step;
            it.note_samples = DIRECTED[i].len;
            offer_item(it, DIRECTED[i].typed, DIRECTED[i].res);
        end
        finish_phase();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            stall_pct     = RECV_STALL_PCT[ph];
            program_voice(ph);
            if (ph == 0)
                hold_req = 1'b1;
            run_notes(RANDOM_PER_PHASE);
            finish_phase();
        end

        if (fail_count == 0)
            $display("** adsr_harmonic_note_voice: PASSED **");
        else
            $display("** adsr_harmonic_note_voice: FAILED **");
        $finish;
    end

endmodule

/* adsr_harmonic_note_voice.f */
hw/rtl/ahnv_pkg.sv
hw/rtl/ahnv_if.sv
hw/rtl/ahnv_regs.sv
hw/rtl/ahnv_front.sv
hw/rtl/ahnv_sine_rom.sv
hw/rtl/ahnv_back.sv
hw/rtl/adsr_harmonic_note_voice.sv
hw/rtl/ahnv_checker.sv
dv/tb_top.sv
